// File: src/pjg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjg_pkg: types and constants of the position jump gate
// Position type, result status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pjg_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SqW      = 2 * PosW;

  typedef logic signed [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_FIRST = 2'd0,
    ST_STEP  = 2'd1,
    ST_JUMP  = 2'd2,
    ST_HELD  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_JUMP_LIMIT = 1'b0,
    CFG_CONFIRM    = 1'b1
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0] JumpLimitRst = 16'd500;
  localparam logic [CountW-1:0]   ConfirmRst   = 8'd3;
  localparam logic [SqW-1:0]      Lim2Rst      = 32'd250000;

  // Open per-axis window around the pending candidate, in mm.
  localparam logic signed [PosW:0] CandWindow  = 17'sd200;
  localparam logic [CountW-1:0]    HitsMax     = 8'hFF;

endpackage

// File: src/position_jump_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_jump_gate: gates sudden jumps in a stream of 3D positions
// Accepts small steps, holds far positions as a candidate until confirmed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with pos_x_i/pos_y_i/pos_z_i; the block drives
//   in_stall_o. A word is taken at a clock edge with valid high, stall low.
//   Output channel: out_valid_o with accepted_o, status_o, out_x/y/z_o and
//   held_count_o; the receiver drives out_stall_i. One result per input word.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the jump limit in mm, index 1 the confirm count. Write only
//   while no word is in flight.
//   out_valid_o rises once a word has passed the input register and the
//   result register; one word is taken every cycle while the receiver does
//   not stall. The rate is set by the single compare stage, whose three
//   17x17 squares, sum and limit compare update the tracking state before
//   the next word reads it.
//   Reset clears the tracking state and the valid bits of both pipeline
//   registers and loads a 500 mm jump limit and a confirm count of three.
//   When the receiver stalls, the result word holds, the input register
//   fills and then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module position_jump_gate
  import pjg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_idx_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pos_t                pos_x_i,
  input  pos_t                pos_y_i,
  input  pos_t                pos_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                accepted_o,
  output status_e             status_o,
  output pos_t                out_x_o,
  output pos_t                out_y_o,
  output pos_t                out_z_o,
  output logic [CountW-1:0]   held_count_o
);

  // Configuration. The squared limit is formed at write time.
  logic [SqW-1:0]    lim2_q;
  logic [CountW-1:0] confirm_q;

  // Input register.
  logic v1_q;
  pos_t x_q, y_q, z_q;

  // Tracking state.
  pos_t              last_x_q, last_y_q, last_z_q;
  logic              have_last_q;
  pos_t              cand_x_q, cand_y_q, cand_z_q;
  logic              have_cand_q;
  logic [CountW-1:0] cand_hits_q;

  // Result register.
  logic              v2_q;
  logic              acc_q;
  status_e           status_q;
  pos_t              ox_q, oy_q, oz_q;
  logic [CountW-1:0] held_q;

  logic advance;
  logic take_in;

  assign advance    = v1_q && (!v2_q || !out_stall_i);
  assign in_stall_o = v1_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Distance to the last accepted position.
  logic signed [PosW:0]   dx, dy, dz;
  logic signed [SqW+1:0]  sqx, sqy, sqz;
  logic [SqW+1:0]         d2;
  logic                   far;

  assign dx  = {x_q[PosW-1], x_q} - {last_x_q[PosW-1], last_x_q};
  assign dy  = {y_q[PosW-1], y_q} - {last_y_q[PosW-1], last_y_q};
  assign dz  = {z_q[PosW-1], z_q} - {last_z_q[PosW-1], last_z_q};
  assign sqx = (SqW+2)'(dx) * (SqW+2)'(dx);
  assign sqy = (SqW+2)'(dy) * (SqW+2)'(dy);
  assign sqz = (SqW+2)'(dz) * (SqW+2)'(dz);
  assign d2  = {2'b00, sqx[SqW-1:0]} + {2'b00, sqy[SqW-1:0]} + {2'b00, sqz[SqW-1:0]};
  assign far = d2 > {2'b00, lim2_q};

  // Candidate window match.
  logic signed [PosW:0] cx, cy, cz;
  logic                 match;
  logic [CountW-1:0]    hits_new;
  logic                 confirmed;

  assign cx = {x_q[PosW-1], x_q} - {cand_x_q[PosW-1], cand_x_q};
  assign cy = {y_q[PosW-1], y_q} - {cand_y_q[PosW-1], cand_y_q};
  assign cz = {z_q[PosW-1], z_q} - {cand_z_q[PosW-1], cand_z_q};
  assign match = have_cand_q
              && (cx < CandWindow) && (cx > -CandWindow)
              && (cy < CandWindow) && (cy > -CandWindow)
              && (cz < CandWindow) && (cz > -CandWindow);
  assign hits_new  = !match ? CountW'(1)
                   : (cand_hits_q == HitsMax) ? HitsMax : cand_hits_q + CountW'(1);
  assign confirmed = hits_new >= confirm_q;

  // Next state and result.
  logic              acc_d;
  status_e           status_d;
  logic              have_cand_d;
  logic [CountW-1:0] cand_hits_d;
  logic              load_cand;

  always_comb begin
    acc_d       = 1'b1;
    status_d    = ST_FIRST;
    have_cand_d = have_cand_q;
    cand_hits_d = cand_hits_q;
    load_cand   = 1'b0;
    priority if (!have_last_q) begin
      status_d = ST_FIRST;
    end else if (far) begin
      load_cand = !match;
      if (confirmed) begin
        status_d    = ST_JUMP;
        have_cand_d = 1'b0;
        cand_hits_d = '0;
      end else begin
        acc_d       = 1'b0;
        status_d    = ST_HELD;
        have_cand_d = 1'b1;
        cand_hits_d = hits_new;
      end
    end else begin
      status_d    = ST_STEP;
      have_cand_d = 1'b0;
      cand_hits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim2_q      <= Lim2Rst;
      confirm_q   <= ConfirmRst;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      have_last_q <= 1'b0;
      have_cand_q <= 1'b0;
      cand_hits_q <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_z_q    <= '0;
      cand_x_q    <= '0;
      cand_y_q    <= '0;
      cand_z_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_JUMP_LIMIT: lim2_q    <= SqW'(cfg_data_i) * SqW'(cfg_data_i);
          CFG_CONFIRM:    confirm_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (take_in) begin
        v1_q <= 1'b1;
      end else if (advance) begin
        v1_q <= 1'b0;
      end
      if (advance) begin
        v2_q <= 1'b1;
      end else if (!out_stall_i) begin
        v2_q <= 1'b0;
      end
      if (advance) begin
        have_cand_q <= have_cand_d;
        cand_hits_q <= cand_hits_d;
        if (load_cand) begin
          cand_x_q <= x_q;
          cand_y_q <= y_q;
          cand_z_q <= z_q;
        end
        if (acc_d) begin
          have_last_q <= 1'b1;
          last_x_q    <= x_q;
          last_y_q    <= y_q;
          last_z_q    <= z_q;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      z_q <= pos_z_i;
    end
    if (advance) begin
      acc_q    <= acc_d;
      status_q <= status_d;
      ox_q     <= acc_d ? x_q : '0;
      oy_q     <= acc_d ? y_q : '0;
      oz_q     <= acc_d ? z_q : '0;
      held_q   <= cand_hits_d;
    end
  end

  assign out_valid_o  = v2_q;
  assign accepted_o   = acc_q;
  assign status_o     = status_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_z_o      = oz_q;
  assign held_count_o = held_q;

  // A result is published exactly when it is not held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (status_o != ST_HELD)))
    else $error("accept flag disagrees with status");

  // Only a held result reports a pending count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_HELD) |-> (held_count_o == '0))
    else $error("pending count on a published result");

  // Once a position has been accepted, there is always a reference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_last_q |=> have_last_q)
    else $error("last position lost");

  // A pending candidate always carries at least one hit, and none otherwise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_cand_q == (cand_hits_q != '0))
    else $error("candidate flag and hit count disagree");

endmodule
